[rtl/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg
// shared types and constants of the periodic task tick scheduler
// ----------------------------------------------------------------------------
package ptts_pkg;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_TICK     = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_ADDED   = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_TICK    = 3'd2,
		KIND_RUN     = 3'd3,
		KIND_NONE    = 3'd4,
		KIND_DELETED = 3'd5,
		KIND_IGNORED = 3'd6
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADD,
		ST_SCAN
	} state_t;

	localparam int TICK_W = 29;
	localparam int RUNS_W = 8;
	localparam int ID_W   = 4;

	localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

	// x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		logic [TICK_W-1:0] countdown;
		logic [TICK_W-1:0] reload_period;
		logic [RUNS_W-1:0] pending_runs;
		logic [ID_W-1:0]   task_ident;
		logic              remove_after_run;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // latch the input item, arm the scan
		logic div;    // register the two quotients
		logic add;    // write the new entry and report
		logic step;   // process the head entry of the table
		logic fin;    // report the closing result of a scan
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rem_zero;  // every entry of the scan has been visited
	} dp_status_t;

endpackage

[rtl/ptts_ctrl.sv]
// ----------------------------------------------------------------------------
// ptts_ctrl
// sequencing state machine: add path and table scan path
// ----------------------------------------------------------------------------
module ptts_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             op,
	input  ptts_pkg::dp_status_t   status,
	output ptts_pkg::ctrl_cmd_t    cmd,
	output logic                   busy
);
	import ptts_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = (op == OP_ADD) ? ST_DIV : ST_SCAN;
				end
			end
			ST_DIV:  state_nxt = ST_ADD;
			ST_ADD:  state_nxt = ST_IDLE;
			ST_SCAN: begin
				if (status.rem_zero) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIV:  cmd.div = 1'b1;
			ST_ADD:  cmd.add = 1'b1;
			ST_SCAN: begin
				cmd.step = !status.rem_zero;
				cmd.fin  = status.rem_zero;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

[rtl/ptts_dpath.sv]
// ----------------------------------------------------------------------------
// ptts_dpath
// task table, divide-by-ten unit, head-entry update and result register
// ----------------------------------------------------------------------------
module ptts_dpath #(
	parameter int MAX_TASKS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptts_pkg::ctrl_cmd_t    cmd,
	output ptts_pkg::dp_status_t   status,
	input  logic [1:0]             op,
	input  logic [31:0]            delay_ms,
	input  logic [31:0]            period_ms,
	input  logic                   one_shot,
	input  logic [3:0]             slot,
	output logic [2:0]             kind,
	output logic [3:0]             task_id,
	output logic                   last,
	output logic                   result_valid
);
	import ptts_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int XW = (CW > 4) ? CW : 4;

	// latched item
	op_t               op_q;
	logic [31:0]       delay_q;
	logic [31:0]       period_q;
	logic              shot_q;
	logic [3:0]        slot_q;

	// quotients
	logic [63:0]       dprod;
	logic [63:0]       pprod;
	logic [TICK_W-1:0] dquo_q;
	logic [TICK_W-1:0] pquo_q;

	// table and scan control
	entry_t            tbl_q [MAX_TASKS];
	entry_t            up_w  [MAX_TASKS];
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     idx_q;
	logic              held_v_q;
	logic [ID_W-1:0]   held_id_q;

	// result register
	logic              res_valid_q;
	kind_t             kind_q;
	logic [ID_W-1:0]   id_q;
	logic              last_q;

	entry_t            head;
	entry_t            head_new;
	entry_t            add_entry;
	logic              head_ready;
	logic              slot_hit;
	logic              drop;
	logic              full;

	assign status.rem_zero = (rem_q == '0);

	assign dprod = 64'(delay_q) * 64'(RECIP10);
	assign pprod = 64'(period_q) * 64'(RECIP10);

	assign head       = tbl_q[0];
	assign head_ready = (head.pending_runs != '0);
	assign slot_hit   = (XW'(idx_q) == XW'(slot_q));
	assign full       = (cnt_q == CW'(MAX_TASKS));

	assign add_entry.countdown        = dquo_q;
	assign add_entry.reload_period    = pquo_q;
	assign add_entry.pending_runs     = '0;
	assign add_entry.task_ident       = ID_W'(cnt_q);
	assign add_entry.remove_after_run = shot_q;

	// new value of the head entry and whether it leaves the table
	always_comb begin
		head_new = head;
		drop     = 1'b0;
		unique case (op_q)
			OP_TICK: begin
				if (head.countdown != '0) begin
					head_new.countdown = head.countdown - TICK_W'(1);
				end else begin
					head_new.countdown = head.reload_period;
					if (head.pending_runs != RUNS_MAX) begin
						head_new.pending_runs = head.pending_runs + RUNS_W'(1);
					end
				end
			end
			OP_DISPATCH: begin
				if (head_ready) begin
					head_new.pending_runs = head.pending_runs - RUNS_W'(1);
					drop = head.remove_after_run;
				end
			end
			OP_DELETE: drop = slot_hit;
			default:   drop = 1'b0;
		endcase
	end

	// entries rotate through the head: each step shifts down and the
	// processed head goes back in at the top of the occupied range
	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_tbl
		if (k < MAX_TASKS - 1) begin : g_up
			assign up_w[k] = tbl_q[k+1];
		end else begin : g_top
			assign up_w[k] = tbl_q[k];
		end

		always_ff @(posedge clk) begin
			if (cmd.add && !full && (CW'(k) == cnt_q)) begin
				tbl_q[k] <= add_entry;
			end else if (cmd.step) begin
				if (!drop && (CW'(k) + CW'(1) == cnt_q)) begin
					tbl_q[k] <= head_new;
				end else if (CW'(k) + CW'(1) < cnt_q) begin
					tbl_q[k] <= up_w[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(op);
			delay_q  <= delay_ms;
			period_q <= period_ms;
			shot_q   <= one_shot;
			slot_q   <= slot;
		end
		if (cmd.div) begin
			dquo_q <= dprod[RECIP_SHIFT +: TICK_W];
			pquo_q <= pprod[RECIP_SHIFT +: TICK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			held_v_q    <= 1'b0;
			held_id_q   <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= KIND_ADDED;
			id_q        <= '0;
			last_q      <= 1'b0;
		end else begin
			res_valid_q <= cmd.add || cmd.fin ||
				(cmd.step && op_q == OP_DISPATCH && head_ready && held_v_q);
			if (cmd.load) begin
				rem_q    <= cnt_q;
				idx_q    <= '0;
				held_v_q <= 1'b0;
			end
			if (cmd.add) begin
				last_q <= 1'b1;
				if (full) begin
					kind_q <= KIND_FULL;
					id_q   <= '0;
				end else begin
					kind_q <= KIND_ADDED;
					id_q   <= ID_W'(cnt_q);
					cnt_q  <= cnt_q + CW'(1);
				end
			end
			if (cmd.step) begin
				rem_q <= rem_q - CW'(1);
				idx_q <= idx_q + CW'(1);
				if (drop) begin
					cnt_q <= cnt_q - CW'(1);
				end
				if (op_q == OP_DISPATCH && head_ready) begin
					// the run found before this one is now known not to be last
					if (held_v_q) begin
						kind_q <= KIND_RUN;
						id_q   <= held_id_q;
						last_q <= 1'b0;
					end
					held_v_q  <= 1'b1;
					held_id_q <= head.task_ident;
				end
				if (op_q == OP_DELETE && slot_hit) begin
					held_v_q  <= 1'b1;
					held_id_q <= head.task_ident;
				end
			end
			if (cmd.fin) begin
				last_q <= 1'b1;
				unique case (op_q)
					OP_DISPATCH: begin
						kind_q <= held_v_q ? KIND_RUN : KIND_NONE;
						id_q   <= held_v_q ? held_id_q : '0;
					end
					OP_DELETE: begin
						kind_q <= held_v_q ? KIND_DELETED : KIND_IGNORED;
						id_q   <= held_v_q ? held_id_q : '0;
					end
					default: begin
						kind_q <= KIND_TICK;
						id_q   <= '0;
					end
				endcase
			end
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign task_id      = id_q;
	assign last         = last_q;

endmodule

[rtl/periodic_task_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// tick-driven cooperative task table with add, tick, dispatch and delete
// ----------------------------------------------------------------------------
// add: strobe registered after divide and write states; next start taken with it
// tick, dispatch, delete: busy while the table rotates one entry per cycle through
//   all N tasks and then the report step; the closing strobe is registered after it
// dispatch results come one per cycle at most, the last one flagged
// reset clears the task count and the strobe; table contents undefined until added
// results are not held: result_valid marks each transfer for one cycle
module periodic_task_tick_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] delay_ms,
	input  logic [31:0] period_ms,
	input  logic        one_shot,
	input  logic [3:0]  slot,
	output logic        result_valid,
	output logic [2:0]  kind,
	output logic [3:0]  task_id,
	output logic        last
);
	import ptts_pkg::*;

	// command and status between the sequencer and the table
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// state machine: add goes through the divide and write steps, the other
	// operations visit every occupied entry once, then report
	ptts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table of tasks, kept compact; the head entry is updated each step and
	// either written back at the top of the occupied range or dropped
	ptts_dpath #(
		.MAX_TASKS (MAX_TASKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.op           (op),
		.delay_ms     (delay_ms),
		.period_ms    (period_ms),
		.one_shot     (one_shot),
		.slot         (slot),
		.kind         (kind),
		.task_id      (task_id),
		.last         (last),
		.result_valid (result_valid)
	);

endmodule
